// File: hdl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared widths, constants and the arctangent table of the odometry core.
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int MUL_A_W   = 40;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = 64;
  localparam int DIV_N_W   = 60;
  localparam int DIV_D_W   = 35;
  localparam int COR_W     = 33;
  localparam int COR_STEPS = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;

  localparam logic OP_CMD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SEP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

  localparam logic [14:0] SEP_RESET     = 15'd2744;
  localparam logic [15:0] RECIP_RESET   = 16'd2560;
  localparam logic [19:0] TIMEOUT_RESET = 20'd1000000;

  localparam logic [20:0] TSC_MAX    = 21'd2097151;
  localparam logic [23:0] ANG_DEN    = 24'd16000000;
  localparam logic [22:0] ANG_HALF   = 23'd8000000;
  localparam logic [19:0] US_PER_S   = 20'd1000000;
  localparam logic [18:0] US_HALF    = 19'd500000;
  localparam logic [21:0] INV_TWO_PI = 22'd2670177;

  localparam logic signed [COR_W-1:0] CORDIC_GAIN = 33'sd652032874;

  function automatic logic signed [COR_W-1:0] atan_entry(input logic [3:0] i);
    logic signed [COR_W-1:0] r;
    case (i)
      4'd0:    r = 33'sd536870912;
      4'd1:    r = 33'sd316933406;
      4'd2:    r = 33'sd167458907;
      4'd3:    r = 33'sd85004756;
      4'd4:    r = 33'sd42667331;
      4'd5:    r = 33'sd21354465;
      4'd6:    r = 33'sd10680862;
      4'd7:    r = 33'sd5340245;
      4'd8:    r = 33'sd2670163;
      4'd9:    r = 33'sd1335087;
      4'd10:   r = 33'sd667544;
      4'd11:   r = 33'sd333772;
      4'd12:   r = 33'sd166886;
      4'd13:   r = 33'sd83443;
      4'd14:   r = 33'sd41721;
      4'd15:   r = 33'sd20860;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/ddo_item_if.sv
// ----------------------------------------------------------------------------
// ddo_item_if
// Input item channel: velocity commands and time ticks.
// ----------------------------------------------------------------------------
interface ddo_item_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] cmd_linear_vel;
  logic signed [15:0] cmd_angular_vel;
  logic [19:0]        step_time_us;

  modport source (output valid, output operation, output cmd_linear_vel,
                  output cmd_angular_vel, output step_time_us, input ready);
  modport sink   (input valid, input operation, input cmd_linear_vel,
                  input cmd_angular_vel, input step_time_us, output ready);
endinterface

// File: hdl/ddo_result_if.sv
// ----------------------------------------------------------------------------
// ddo_result_if
// Result item channel: pose, body velocity and wheel state.
// ----------------------------------------------------------------------------
interface ddo_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic [15:0]        heading;
  logic signed [15:0] body_linear_vel;
  logic signed [15:0] body_angular_vel;
  logic signed [31:0] left_wheel_angle;
  logic signed [31:0] right_wheel_angle;
  logic signed [15:0] left_wheel_rate;
  logic signed [15:0] right_wheel_rate;

  modport source (output valid, output pose_x, output pose_y, output heading,
                  output body_linear_vel, output body_angular_vel,
                  output left_wheel_angle, output right_wheel_angle,
                  output left_wheel_rate, output right_wheel_rate, input ready);
  modport sink   (input valid, input pose_x, input pose_y, input heading,
                  input body_linear_vel, input body_angular_vel,
                  input left_wheel_angle, input right_wheel_angle,
                  input left_wheel_rate, input right_wheel_rate, output ready);
endinterface

// File: hdl/ddo_cfg_if.sv
// ----------------------------------------------------------------------------
// ddo_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ddo_cfg_if import ddo_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/diff_drive_odometry_core.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry_core
// Differential-drive odometry: wheel speeds from body commands, timeout,
// wheel angle integration and dead-reckoned pose with a half-angle update.
//
//   channel  dir  handshake     carries
//   item     in   valid/ready   operation, command speeds, step time
//   result   out  valid/ready   pose, heading, body velocity, wheel state
//   cfg      in   valid/ready   register index, write data
//
// A command item takes one multiplier pass; a tick takes eleven passes of
// the bit-serial multiplier, five of the bit-serial divider and one CORDIC
// run. One item is in work at a time; item.ready is high only when idle.
// A finished result waits in the output register; a new item is taken
// meanwhile and its tick stalls at the end until that result is taken.
// Synchronous reset clears the odometry state and loads the register defaults.
// ----------------------------------------------------------------------------
module diff_drive_odometry_core import ddo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ddo_item_if.sink    item,
  ddo_result_if.source result,
  ddo_cfg_if.sink     cfg
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_CMD  = 5'd1;
  localparam logic [4:0] ST_TIME = 5'd2;
  localparam logic [4:0] ST_PREP = 5'd3;
  localparam logic [4:0] ST_RD   = 5'd4;
  localparam logic [4:0] ST_LM   = 5'd5;
  localparam logic [4:0] ST_LD   = 5'd6;
  localparam logic [4:0] ST_RM   = 5'd7;
  localparam logic [4:0] ST_RDV  = 5'd8;
  localparam logic [4:0] ST_SM   = 5'd9;
  localparam logic [4:0] ST_SD   = 5'd10;
  localparam logic [4:0] ST_SEPM = 5'd11;
  localparam logic [4:0] ST_DM   = 5'd12;
  localparam logic [4:0] ST_DK   = 5'd13;
  localparam logic [4:0] ST_DD   = 5'd14;
  localparam logic [4:0] ST_CORD = 5'd15;
  localparam logic [4:0] ST_XM   = 5'd16;
  localparam logic [4:0] ST_YM   = 5'd17;
  localparam logic [4:0] ST_AD   = 5'd18;
  localparam logic [4:0] ST_LR   = 5'd19;
  localparam logic [4:0] ST_RR   = 5'd20;
  localparam logic [4:0] ST_EMIT = 5'd21;

  // registers
  logic [14:0] sep_reg;
  logic [15:0] recip_reg;
  logic [19:0] timeout_reg;

  // odometry state
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;
  logic [20:0]        tsc;
  logic [31:0]        pos_x;
  logic [31:0]        pos_y;
  logic [15:0]        yaw;
  logic [31:0]        lang;
  logic [31:0]        rang;

  // sequencer
  logic [4:0] state;
  logic       phase;

  // working values
  logic signed [15:0] v_reg;
  logic signed [15:0] w_reg;
  logic [19:0]        dt_reg;
  logic signed [16:0] vsum;
  logic signed [16:0] vdiff;
  logic [35:0]        rd;
  logic [34:0]        sepm;
  logic [19:0]        ds_mag;
  logic [15:0]        mid;
  logic signed [15:0] ang_vel;
  logic signed [15:0] lrate;
  logic signed [15:0] rrate;

  // output register
  logic               res_valid;
  logic [31:0]        out_x;
  logic [31:0]        out_y;
  logic [15:0]        out_heading;
  logic signed [15:0] out_lin;
  logic signed [15:0] out_ang;
  logic [31:0]        out_lang;
  logic [31:0]        out_rang;
  logic signed [15:0] out_lrate;
  logic signed [15:0] out_rrate;

  // units
  logic                    use_mul;
  logic                    use_div;
  logic                    use_cor;
  logic                    mul_start;
  logic                    div_start;
  logic                    cor_start;
  logic                    mul_done;
  logic                    div_done;
  logic                    cor_done;
  logic                    unit_done;
  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [MUL_P_W-1:0]      prod;
  logic [DIV_N_W-1:0]      div_num;
  logic [DIV_D_W-1:0]      div_den;
  logic [DIV_N_W-1:0]      quo;
  logic signed [COR_W-1:0] cor_cos;
  logic signed [COR_W-1:0] cor_sin;

  // derived
  logic [14:0]             sep_eff;
  logic [15:0]             l_mag;
  logic [15:0]             r_mag;
  logic [15:0]             w_mag;
  logic [16:0]             sum_mag;
  logic [16:0]             diff_mag;
  logic signed [COR_W-1:0] cos_abs;
  logic signed [COR_W-1:0] sin_abs;
  logic [31:0]             q32;
  logic [32:0]             term_sum;
  logic signed [20:0]      term;
  logic signed [20:0]      v_ext;
  logic [32:0]             rate_sum;
  logic [31:0]             rate_mag;
  logic [52:0]             xy_sum;
  logic [31:0]             xy_mag;
  logic [25:0]             r512_sum;
  logic [25:0]             r256_sum;
  logic [15:0]             r512;
  logic [15:0]             r256;
  logic [17:0]             bl_sum;
  logic [21:0]             t_sum;
  logic [20:0]             tsc_new;

  function automatic logic signed [15:0] sat_mag(input logic [31:0] mag, input logic neg);
    logic signed [15:0] r;
    if (neg) begin
      r = (mag > 32'd32768) ? 16'sh8000 : 16'(~mag[15:0] + 16'd1);
    end else begin
      r = (mag > 32'd32767) ? 16'sh7FFF : mag[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat21(input logic signed [20:0] v);
    logic signed [15:0] r;
    if (v > 21'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -21'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign sep_eff  = (sep_reg == '0) ? 15'd1 : sep_reg;
  assign l_mag    = left_speed[15] ? 16'(-left_speed) : 16'(left_speed);
  assign r_mag    = right_speed[15] ? 16'(-right_speed) : 16'(right_speed);
  assign w_mag    = w_reg[15] ? 16'(-w_reg) : 16'(w_reg);
  assign sum_mag  = vsum[16] ? 17'(-vsum) : 17'(vsum);
  assign diff_mag = vdiff[16] ? 17'(-vdiff) : 17'(vdiff);
  assign cos_abs  = cor_cos[COR_W-1] ? -cor_cos : cor_cos;
  assign sin_abs  = cor_sin[COR_W-1] ? -cor_sin : cor_sin;
  assign q32      = quo[31:0];

  assign term_sum = {1'b0, prod[31:0]} + 33'd4096;
  assign term     = w_reg[15] ? -$signed({1'b0, term_sum[32:13]})
                              : $signed({1'b0, term_sum[32:13]});
  assign v_ext    = 21'(v_reg);
  assign rate_sum = {1'b0, prod[31:0]} + 33'd2048;
  assign rate_mag = 32'(rate_sum[32:12]);
  assign xy_sum   = {1'b0, prod[51:0]} + 53'h2000_0000;
  assign xy_mag   = 32'(xy_sum[52:30]);
  assign r512_sum = {1'b0, quo[24:0]} + 26'd256;
  assign r256_sum = {1'b0, quo[24:0]} + 26'd128;
  assign r512     = r512_sum[24:9];
  assign r256     = r256_sum[23:8];
  assign bl_sum   = {1'b0, sum_mag} + 18'd1;
  assign t_sum    = {1'b0, tsc} + 22'(dt_reg);
  assign tsc_new  = (t_sum > 22'(TSC_MAX)) ? TSC_MAX : t_sum[20:0];

  // unit operands per step
  always_comb begin
    use_mul = 1'b0;
    use_div = 1'b0;
    use_cor = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_num = '0;
    div_den = '0;
    case (state)
      ST_CMD: begin
        use_mul = 1'b1;
        mul_a   = MUL_A_W'(w_mag);
        mul_b   = MUL_B_W'(sep_eff);
      end
      ST_RD: begin
        use_mul = 1'b1;
        mul_a   = MUL_A_W'(recip_reg);
        mul_b   = MUL_B_W'(dt_reg);
      end
      ST_LM: begin
        use_mul = 1'b1;
        mul_a   = MUL_A_W'(rd);
        mul_b   = MUL_B_W'(l_mag);
      end
      ST_RM: begin
        use_mul = 1'b1;
        mul_a   = MUL_A_W'(rd);
        mul_b   = MUL_B_W'(r_mag);
      end
      ST_LD, ST_RDV: begin
        use_div = 1'b1;
        div_num = DIV_N_W'(prod[51:0]) + DIV_N_W'(ANG_HALF);
        div_den = DIV_D_W'(ANG_DEN);
      end
      ST_SM: begin
        use_mul = 1'b1;
        mul_a   = MUL_A_W'(sum_mag);
        mul_b   = MUL_B_W'(dt_reg);
      end
      ST_SD: begin
        use_div = 1'b1;
        div_num = DIV_N_W'({prod[39:0], 3'b000}) + DIV_N_W'(US_HALF);
        div_den = DIV_D_W'(US_PER_S);
      end
      ST_SEPM: begin
        use_mul = 1'b1;
        mul_a   = MUL_A_W'(sep_eff);
        mul_b   = MUL_B_W'(US_PER_S);
      end
      ST_DM: begin
        use_mul = 1'b1;
        mul_a   = MUL_A_W'(diff_mag);
        mul_b   = MUL_B_W'(dt_reg);
      end
      ST_DK: begin
        use_mul = 1'b1;
        mul_a   = prod[MUL_A_W-1:0];
        mul_b   = MUL_B_W'(INV_TWO_PI);
      end
      ST_DD: begin
        use_div = 1'b1;
        div_num = DIV_N_W'(prod[57:0]) + DIV_N_W'(sepm[DIV_D_W-1:1]);
        div_den = sepm;
      end
      ST_CORD: begin
        use_cor = 1'b1;
      end
      ST_XM: begin
        use_mul = 1'b1;
        mul_a   = MUL_A_W'(ds_mag);
        mul_b   = cos_abs[MUL_B_W-1:0];
      end
      ST_YM: begin
        use_mul = 1'b1;
        mul_a   = MUL_A_W'(ds_mag);
        mul_b   = sin_abs[MUL_B_W-1:0];
      end
      ST_AD: begin
        use_div = 1'b1;
        div_num = DIV_N_W'({diff_mag, 12'h000}) + DIV_N_W'(sep_eff[14:1]);
        div_den = DIV_D_W'(sep_eff);
      end
      ST_LR: begin
        use_mul = 1'b1;
        mul_a   = MUL_A_W'(l_mag);
        mul_b   = MUL_B_W'(recip_reg);
      end
      ST_RR: begin
        use_mul = 1'b1;
        mul_a   = MUL_A_W'(r_mag);
        mul_b   = MUL_B_W'(recip_reg);
      end
      default: ;
    endcase
  end

  assign mul_start = use_mul && !phase;
  assign div_start = use_div && !phase;
  assign cor_start = use_cor && !phase;
  assign unit_done = (use_mul && mul_done) || (use_div && div_done) || (use_cor && cor_done);

  ddo_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  ddo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  ddo_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (mid),
    .done    (cor_done),
    .cos_val (cor_cos),
    .sin_val (cor_sin)
  );

  assign item.ready = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;

  assign result.valid             = res_valid;
  assign result.pose_x            = out_x;
  assign result.pose_y            = out_y;
  assign result.heading           = out_heading;
  assign result.body_linear_vel   = out_lin;
  assign result.body_angular_vel  = out_ang;
  assign result.left_wheel_angle  = out_lang;
  assign result.right_wheel_angle = out_rang;
  assign result.left_wheel_rate   = out_lrate;
  assign result.right_wheel_rate  = out_rrate;

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_reg     <= SEP_RESET;
      recip_reg   <= RECIP_RESET;
      timeout_reg <= TIMEOUT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SEP:     sep_reg     <= cfg.data[14:0];
        REG_RECIP:   recip_reg   <= cfg.data[15:0];
        REG_TIMEOUT: timeout_reg <= cfg.data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= 1'b0;
      res_valid   <= 1'b0;
      left_speed  <= '0;
      right_speed <= '0;
      tsc         <= '0;
      pos_x       <= '0;
      pos_y       <= '0;
      yaw         <= '0;
      lang        <= '0;
      rang        <= '0;
    end else begin
      if (result.ready && state != ST_EMIT) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item.valid) begin
            if (item.operation == OP_CMD) begin
              v_reg <= item.cmd_linear_vel;
              w_reg <= item.cmd_angular_vel;
              state <= ST_CMD;
            end else begin
              dt_reg <= item.step_time_us;
              state  <= ST_TIME;
            end
          end
        end
        ST_TIME: begin
          tsc <= tsc_new;
          if (tsc_new > 21'(timeout_reg)) begin
            left_speed  <= '0;
            right_speed <= '0;
          end
          state <= ST_PREP;
        end
        ST_PREP: begin
          vsum  <= 17'(left_speed) + 17'(right_speed);
          vdiff <= 17'(right_speed) - 17'(left_speed);
          state <= ST_RD;
        end
        ST_EMIT: begin
          if (!res_valid || result.ready) begin
            res_valid   <= 1'b1;
            out_x       <= pos_x;
            out_y       <= pos_y;
            out_heading <= yaw;
            out_lang    <= lang;
            out_rang    <= rang;
            out_lrate   <= lrate;
            out_rrate   <= rrate;
            if (dt_reg == '0) begin
              out_lin <= '0;
              out_ang <= '0;
            end else begin
              out_lin <= sat_mag(32'(bl_sum[17:1]), vsum[16]);
              out_ang <= ang_vel;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          if (!phase) begin
            phase <= 1'b1;
          end else if (unit_done) begin
            phase <= 1'b0;
            case (state)
              ST_CMD: begin
                left_speed  <= sat21(v_ext + term);
                right_speed <= sat21(v_ext - term);
                tsc         <= '0;
                state       <= ST_IDLE;
              end
              ST_RD: begin
                rd    <= prod[35:0];
                state <= ST_LM;
              end
              ST_LM: state <= ST_LD;
              ST_LD: begin
                lang  <= lang + (left_speed[15] ? -q32 : q32);
                state <= ST_RM;
              end
              ST_RM: state <= ST_RDV;
              ST_RDV: begin
                rang  <= rang + (right_speed[15] ? -q32 : q32);
                state <= ST_SM;
              end
              ST_SM: state <= ST_SD;
              ST_SD: begin
                ds_mag <= quo[19:0];
                state  <= ST_SEPM;
              end
              ST_SEPM: begin
                sepm  <= prod[34:0];
                state <= ST_DM;
              end
              ST_DM: state <= ST_DK;
              ST_DK: state <= ST_DD;
              ST_DD: begin
                mid   <= yaw + (vdiff[16] ? -r512 : r512);
                yaw   <= yaw + (vdiff[16] ? -r256 : r256);
                state <= ST_CORD;
              end
              ST_CORD: state <= ST_XM;
              ST_XM: begin
                pos_x <= pos_x + ((vsum[16] ^ cor_cos[COR_W-1]) ? -xy_mag : xy_mag);
                state <= ST_YM;
              end
              ST_YM: begin
                pos_y <= pos_y + ((vsum[16] ^ cor_sin[COR_W-1]) ? -xy_mag : xy_mag);
                state <= ST_AD;
              end
              ST_AD: begin
                ang_vel <= sat_mag(q32, vdiff[16]);
                state   <= ST_LR;
              end
              ST_LR: begin
                lrate <= sat_mag(rate_mag, left_speed[15]);
                state <= ST_RR;
              end
              ST_RR: begin
                rrate <= sat_mag(rate_mag, right_speed[15]);
                state <= ST_EMIT;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({mul_start, div_start, cor_start}))
    else $error("more than one arithmetic unit started");

  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_EMIT)
    else $error("result raised outside the emit step");

  a_timeout: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PREP && tsc > {1'b0, timeout_reg}) |->
      (left_speed == '0 && right_speed == '0))
    else $error("wheel speeds not zeroed after timeout");
`endif

endmodule

// File: hdl/ddo_mul.sv
// ----------------------------------------------------------------------------
// ddo_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ddo_mul import ddo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [MUL_P_W-1:0] prod
);

  localparam int CNT_W = $clog2(MUL_B_W + 1);

  logic [MUL_A_W-1:0]         a_reg;
  logic [MUL_A_W-1:0]         hi;
  logic [MUL_B_W-1:0]         lo;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic [MUL_A_W:0]           sum;
  logic [MUL_A_W+MUL_B_W-1:0] full;

  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, a_reg} : '0);
  assign full = {hi, lo};
  assign prod = full[MUL_P_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      hi    <= '0;
      lo    <= b;
    end else if (busy) begin
      hi <= sum[MUL_A_W:1];
      lo <= {sum[0], lo[MUL_B_W-1:1]};
    end
  end

endmodule

// File: hdl/ddo_div.sv
// ----------------------------------------------------------------------------
// ddo_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ddo_div import ddo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] num,
  input  logic [DIV_D_W-1:0] den,
  output logic               done,
  output logic [DIV_N_W-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic [DIV_N_W-1:0] q;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W-1:0] d_reg;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [DIV_D_W:0]   rs;
  logic [DIV_D_W:0]   sub;
  logic               ge;

  assign rs  = {rem, q[DIV_N_W-1]};
  assign ge  = rs >= {1'b0, d_reg};
  assign sub = rs - {1'b0, d_reg};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q     <= num;
      rem   <= '0;
      d_reg <= den;
    end else if (busy) begin
      rem <= ge ? sub[DIV_D_W-1:0] : rs[DIV_D_W-1:0];
      q   <= {q[DIV_N_W-2:0], ge};
    end
  end

endmodule

// File: hdl/ddo_cordic.sv
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation CORDIC, one micro-rotation per cycle, Q2.30 cos and sin.
// ----------------------------------------------------------------------------
module ddo_cordic import ddo_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [15:0]             angle,
  output logic                    done,
  output logic signed [COR_W-1:0] cos_val,
  output logic signed [COR_W-1:0] sin_val
);

  localparam int CNT_W = $clog2(COR_STEPS);

  logic signed [COR_W-1:0] x;
  logic signed [COR_W-1:0] y;
  logic signed [COR_W-1:0] z;
  logic signed [COR_W-1:0] xs;
  logic signed [COR_W-1:0] ys;
  logic signed [COR_W-1:0] at;
  logic [1:0]              quad;
  logic [CNT_W-1:0]        cnt;
  logic                    busy;

  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign at = atan_entry(4'(cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(COR_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= COR_W'({angle[13:0], 16'h0000});
      quad <= angle[15:14];
    end else if (busy) begin
      if (!z[COR_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

  // rotate back by quadrant
  always_comb begin
    case (quad)
      2'd0: begin
        cos_val = x;
        sin_val = y;
      end
      2'd1: begin
        cos_val = -y;
        sin_val = x;
      end
      2'd2: begin
        cos_val = -x;
        sin_val = -y;
      end
      default: begin
        cos_val = y;
        sin_val = -x;
      end
    endcase
  end

endmodule
